// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define WRHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// antecedent implies consequent on the next edge
`define WRHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/wrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrhp_pkg
// shared types, constants and tables of the riff/wave header parser
// ----------------------------------------------------------------------------
package wrhp_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_END     = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_END    = 3'd1,
    ST_BAD_ID = 3'd2,
    ST_UNSUP  = 3'd3,
    ST_NO_FMT = 3'd4
  } status_e;

  localparam logic [31:0] ID_RIFF      = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE      = 32'h4556_4157;
  localparam logic [31:0] ID_FMT       = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA      = 32'h6174_6164;
  localparam logic [31:0] MASK_UNKNOWN = 32'h8000_0000;
  localparam logic [31:0] MASK_MONO    = 32'h0000_0004;
  localparam logic [31:0] MASK_STEREO  = 32'h0000_0003;
  localparam logic [15:0] TAG_EXT      = 16'hFFFE;
  localparam logic [15:0] TAG_PCM      = 16'h0001;
  localparam logic [15:0] TAG_FLOAT    = 16'h0003;
  localparam logic [15:0] TAG_ALAW     = 16'h0006;
  localparam logic [15:0] TAG_MULAW    = 16'h0007;

  localparam logic [1:0] FMT_PCM   = 2'd0;
  localparam logic [1:0] FMT_FLOAT = 2'd1;
  localparam logic [1:0] FMT_ALAW  = 2'd2;
  localparam logic [1:0] FMT_MULAW = 2'd3;

  typedef struct packed {
    logic       tag_ok;
    logic       rate_ok;
    logic [1:0] format;
  } fmt_chk_t;

  // fixed tail of the subformat guid, after the two tag bytes
  function automatic logic [7:0] guid_tail(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd4:    b = 8'h10;
      4'd6:    b = 8'h80;
      4'd9:    b = 8'hAA;
      4'd11:   b = 8'h38;
      4'd12:   b = 8'h9B;
      4'd13:   b = 8'h71;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/wrhp_fmt_check.sv =====
// ----------------------------------------------------------------------------
// wrhp_fmt_check
// format tag mapping and byte rate check against block align times rate
// ----------------------------------------------------------------------------
module wrhp_fmt_check (
  input  logic               clk_i,
  input  logic [15:0]        block_i,
  input  logic [31:0]        rate_i,
  input  logic [31:0]        avg_i,
  input  logic [15:0]        tag_i,
  output wrhp_pkg::fmt_chk_t chk_o
);

  logic [31:0] prod_d, prod_q;

  // block align is known at least two requests before any check
  assign prod_d = {16'd0, block_i} * rate_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    chk_o.tag_ok  = 1'b1;
    chk_o.rate_ok = (avg_i == prod_q);
    unique case (tag_i)
      wrhp_pkg::TAG_PCM:   chk_o.format = wrhp_pkg::FMT_PCM;
      wrhp_pkg::TAG_FLOAT: chk_o.format = wrhp_pkg::FMT_FLOAT;
      wrhp_pkg::TAG_ALAW:  chk_o.format = wrhp_pkg::FMT_ALAW;
      wrhp_pkg::TAG_MULAW: chk_o.format = wrhp_pkg::FMT_MULAW;
      default: begin
        chk_o.format = wrhp_pkg::FMT_PCM;
        chk_o.tag_ok = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/wav_riff_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// wav_riff_header_parser_top
// byte-wide riff/wave header walker giving one summary result per header
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid_i/in_ready_o  | cmd_i, byte_in_i
//  out     | out_valid_o/out_ready_i| status_o .. data_bytes_o
//
//  one request per cycle while in_ready_o is high, each handled in the cycle it is taken
//  a result appears in the output register the cycle after its request
//  in_ready_o is low only while a result waits and out_ready_i is low
//  rst_ni clears all state at once, but not the output payload registers; no clearing pass
// ----------------------------------------------------------------------------
module wav_riff_header_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  sample_format_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [15:0] block_bytes_o,
  output logic [15:0] sample_bits_o,
  output logic [15:0] valid_bits_o,
  output logic [31:0] speaker_mask_o,
  output logic [31:0] data_bytes_o
);

  typedef enum logic [4:0] {
    PH_RIFF  = 5'd0,
    PH_RSIZE = 5'd1,
    PH_WAVE  = 5'd2,
    PH_CKID  = 5'd3,
    PH_CKSZ  = 5'd4,
    PH_SKIP  = 5'd5,
    PH_TAG   = 5'd6,
    PH_CHAN  = 5'd7,
    PH_RATE  = 5'd8,
    PH_AVG   = 5'd9,
    PH_ALIGN = 5'd10,
    PH_BITS  = 5'd11,
    PH_CB    = 5'd12,
    PH_VALID = 5'd13,
    PH_MASK  = 5'd14,
    PH_SUB   = 5'd15,
    PH_DONE  = 5'd16
  } phase_e;

  phase_e      phase_d, phase_q;
  logic [4:0]  cnt_d, cnt_q;
  logic [31:0] word_d, word_q;
  logic [31:0] skip_d, skip_q;
  logic [31:0] ckid_d, ckid_q;
  logic        fmt_ext_d, fmt_ext_q;
  logic [15:0] tag_d, tag_q;
  logic [15:0] sub_d, sub_q;
  logic        guid_d, guid_q;
  logic [31:0] avg_d, avg_q;
  logic        seen_d, seen_q;
  logic        ext_d, ext_q;
  logic [15:0] chan_d, chan_q;
  logic [31:0] rate_d, rate_q;
  logic [15:0] block_d, block_q;
  logic [15:0] bits_d, bits_q;
  logic [15:0] vbits_d, vbits_q;
  logic [31:0] mask_d, mask_q;
  logic [1:0]  fmt_d, fmt_q;

  logic        out_valid_d, out_valid_q;
  logic [2:0]  o_status_d, o_status_q;
  logic [1:0]  o_format_d, o_format_q;
  logic [15:0] o_chan_d, o_chan_q;
  logic [31:0] o_rate_d, o_rate_q;
  logic [15:0] o_block_d, o_block_q;
  logic [15:0] o_bits_d, o_bits_q;
  logic [15:0] o_vbits_d, o_vbits_q;
  logic [31:0] o_mask_d, o_mask_q;
  logic [31:0] o_size_d, o_size_q;

  logic                accept;
  logic [31:0]         val;
  logic [4:0]          plen;
  logic                last;
  logic [3:0]          sub_idx;
  logic                emit;
  wrhp_pkg::status_e   emit_status;
  logic                emit_good;
  logic [31:0]         emit_size;
  logic                finish;
  logic                fmt_ok;
  logic [31:0]         mask_out;
  logic [15:0]         tag_sel;
  wrhp_pkg::fmt_chk_t  chk;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign tag_sel    = (tag_q == wrhp_pkg::TAG_EXT) ? sub_q : tag_q;

  wrhp_fmt_check u_fmt_check (
    .clk_i   (clk_i),
    .block_i (block_q),
    .rate_i  (rate_q),
    .avg_i   (avg_q),
    .tag_i   (tag_sel),
    .chk_o   (chk)
  );

  assign val     = word_q | ({24'd0, byte_in_i} << {cnt_q[1:0], 3'b000});
  assign sub_idx = cnt_q[3:0];
  assign last    = ((cnt_q + 5'd1) >= plen);

  always_comb begin
    unique case (phase_q)
      PH_TAG, PH_CHAN, PH_ALIGN, PH_BITS, PH_CB, PH_VALID: plen = 5'd2;
      default:                                             plen = 5'd4;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    word_d    = word_q;
    skip_d    = skip_q;
    ckid_d    = ckid_q;
    fmt_ext_d = fmt_ext_q;
    tag_d     = tag_q;
    sub_d     = sub_q;
    guid_d    = guid_q;
    avg_d     = avg_q;
    seen_d    = seen_q;
    ext_d     = ext_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    block_d   = block_q;
    bits_d    = bits_q;
    vbits_d   = vbits_q;
    mask_d    = mask_q;
    fmt_d     = fmt_q;
    emit        = 1'b0;
    emit_status = wrhp_pkg::ST_OK;
    emit_good   = 1'b0;
    emit_size   = 32'd0;
    finish      = 1'b0;

    if (accept) begin
      unique case (wrhp_pkg::cmd_e'(cmd_i))
        wrhp_pkg::CMD_RESTART: begin
          phase_d   = PH_RIFF;
          cnt_d     = 5'd0;
          word_d    = 32'd0;
          skip_d    = 32'd0;
          ckid_d    = 32'd0;
          fmt_ext_d = 1'b0;
          tag_d     = 16'd0;
          sub_d     = 16'd0;
          guid_d    = 1'b1;
          avg_d     = 32'd0;
          seen_d    = 1'b0;
          ext_d     = 1'b0;
          chan_d    = 16'd0;
          rate_d    = 32'd0;
          block_d   = 16'd0;
          bits_d    = 16'd0;
          vbits_d   = 16'd0;
          mask_d    = wrhp_pkg::MASK_UNKNOWN;
          fmt_d     = wrhp_pkg::FMT_PCM;
        end
        wrhp_pkg::CMD_END: begin
          if (phase_q != PH_DONE) begin
            emit        = 1'b1;
            emit_status = wrhp_pkg::ST_END;
          end
        end
        wrhp_pkg::CMD_BYTE: begin
          if (phase_q == PH_SKIP) begin
            skip_d = skip_q - 32'd1;
            if (skip_q == 32'd1) begin
              phase_d = PH_CKID;
            end
          end else if (phase_q == PH_SUB) begin
            if (sub_idx < 4'd2) begin
              sub_d = sub_q | ({8'd0, byte_in_i} << {sub_idx[0], 3'b000});
            end else if (byte_in_i != wrhp_pkg::guid_tail(sub_idx - 4'd2)) begin
              guid_d = 1'b0;
            end
            if (sub_idx == 4'd15) begin
              cnt_d  = 5'd0;
              finish = 1'b1;
            end else begin
              cnt_d = {1'b0, sub_idx + 4'd1};
            end
          end else if (phase_q != PH_DONE) begin
            if (!last) begin
              word_d = val;
              cnt_d  = cnt_q + 5'd1;
            end else begin
              word_d = 32'd0;
              cnt_d  = 5'd0;
              unique case (phase_q)
                PH_RIFF: begin
                  if (val != wrhp_pkg::ID_RIFF) begin
                    emit        = 1'b1;
                    emit_status = wrhp_pkg::ST_BAD_ID;
                  end else begin
                    phase_d = PH_RSIZE;
                  end
                end
                PH_RSIZE: phase_d = PH_WAVE;
                PH_WAVE: begin
                  if (val != wrhp_pkg::ID_WAVE) begin
                    emit        = 1'b1;
                    emit_status = wrhp_pkg::ST_BAD_ID;
                  end else begin
                    phase_d = PH_CKID;
                  end
                end
                PH_CKID: begin
                  ckid_d  = val;
                  phase_d = PH_CKSZ;
                end
                PH_CKSZ: begin
                  if (ckid_q == wrhp_pkg::ID_DATA) begin
                    emit = 1'b1;
                    if (!seen_q) begin
                      emit_status = wrhp_pkg::ST_NO_FMT;
                    end else begin
                      emit_good = 1'b1;
                      emit_size = val;
                    end
                  end else if (ckid_q == wrhp_pkg::ID_FMT) begin
                    fmt_ext_d = (val > 32'd16);
                    ext_d     = 1'b0;
                    guid_d    = 1'b1;
                    sub_d     = 16'd0;
                    phase_d   = PH_TAG;
                  end else begin
                    skip_d  = val;
                    phase_d = (val == 32'd0) ? PH_CKID : PH_SKIP;
                  end
                end
                PH_TAG: begin
                  tag_d   = val[15:0];
                  phase_d = PH_CHAN;
                end
                PH_CHAN: begin
                  chan_d  = val[15:0];
                  phase_d = PH_RATE;
                end
                PH_RATE: begin
                  rate_d  = val;
                  phase_d = PH_AVG;
                end
                PH_AVG: begin
                  avg_d   = val;
                  phase_d = PH_ALIGN;
                end
                PH_ALIGN: begin
                  block_d = val[15:0];
                  phase_d = PH_BITS;
                end
                PH_BITS: begin
                  bits_d  = val[15:0];
                  vbits_d = val[15:0];
                  if (fmt_ext_q) begin
                    phase_d = PH_CB;
                  end else begin
                    finish = 1'b1;
                  end
                end
                PH_CB: begin
                  if (val[15:0] != 16'd0) begin
                    phase_d = PH_VALID;
                  end else begin
                    finish = 1'b1;
                  end
                end
                PH_VALID: begin
                  vbits_d = val[15:0];
                  phase_d = PH_MASK;
                end
                PH_MASK: begin
                  mask_d  = val;
                  ext_d   = 1'b1;
                  phase_d = PH_SUB;
                end
                default: phase_d = PH_DONE;
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    fmt_ok = !(ext_q && !guid_d) && chk.tag_ok && chk.rate_ok;
    if (finish) begin
      if (fmt_ok) begin
        fmt_d   = chk.format;
        seen_d  = 1'b1;
        phase_d = PH_CKID;
      end else begin
        emit        = 1'b1;
        emit_status = wrhp_pkg::ST_UNSUP;
      end
    end

    if (emit) begin
      phase_d = PH_DONE;
    end
  end

  always_comb begin
    mask_out = mask_q;
    if (mask_q == wrhp_pkg::MASK_UNKNOWN) begin
      if (chan_q == 16'd1) begin
        mask_out = wrhp_pkg::MASK_MONO;
      end else if (chan_q == 16'd2) begin
        mask_out = wrhp_pkg::MASK_STEREO;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    o_status_d  = o_status_q;
    o_format_d  = o_format_q;
    o_chan_d    = o_chan_q;
    o_rate_d    = o_rate_q;
    o_block_d   = o_block_q;
    o_bits_d    = o_bits_q;
    o_vbits_d   = o_vbits_q;
    o_mask_d    = o_mask_q;
    o_size_d    = o_size_q;
    if (emit) begin
      out_valid_d = 1'b1;
      o_status_d  = emit_status;
      o_format_d  = emit_good ? fmt_q : 2'd0;
      o_chan_d    = emit_good ? chan_q : 16'd0;
      o_rate_d    = emit_good ? rate_q : 32'd0;
      o_block_d   = emit_good ? block_q : 16'd0;
      o_bits_d    = emit_good ? bits_q : 16'd0;
      o_vbits_d   = emit_good ? vbits_q : 16'd0;
      o_mask_d    = emit_good ? mask_out : 32'd0;
      o_size_d    = emit_size;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF;
      cnt_q       <= 5'd0;
      word_q      <= 32'd0;
      skip_q      <= 32'd0;
      ckid_q      <= 32'd0;
      fmt_ext_q   <= 1'b0;
      tag_q       <= 16'd0;
      sub_q       <= 16'd0;
      guid_q      <= 1'b1;
      avg_q       <= 32'd0;
      seen_q      <= 1'b0;
      ext_q       <= 1'b0;
      chan_q      <= 16'd0;
      rate_q      <= 32'd0;
      block_q     <= 16'd0;
      bits_q      <= 16'd0;
      vbits_q     <= 16'd0;
      mask_q      <= wrhp_pkg::MASK_UNKNOWN;
      fmt_q       <= wrhp_pkg::FMT_PCM;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      word_q      <= word_d;
      skip_q      <= skip_d;
      ckid_q      <= ckid_d;
      fmt_ext_q   <= fmt_ext_d;
      tag_q       <= tag_d;
      sub_q       <= sub_d;
      guid_q      <= guid_d;
      avg_q       <= avg_d;
      seen_q      <= seen_d;
      ext_q       <= ext_d;
      chan_q      <= chan_d;
      rate_q      <= rate_d;
      block_q     <= block_d;
      bits_q      <= bits_d;
      vbits_q     <= vbits_d;
      mask_q      <= mask_d;
      fmt_q       <= fmt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_status_q <= o_status_d;
    o_format_q <= o_format_d;
    o_chan_q   <= o_chan_d;
    o_rate_q   <= o_rate_d;
    o_block_q  <= o_block_d;
    o_bits_q   <= o_bits_d;
    o_vbits_q  <= o_vbits_d;
    o_mask_q   <= o_mask_d;
    o_size_q   <= o_size_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign sample_format_o = o_format_q;
  assign channel_count_o = o_chan_q;
  assign sample_rate_o   = o_rate_q;
  assign block_bytes_o   = o_block_q;
  assign sample_bits_o   = o_bits_q;
  assign valid_bits_o    = o_vbits_q;
  assign speaker_mask_o  = o_mask_q;
  assign data_bytes_o    = o_size_q;

endmodule

// ===== hw/rtl/wrhp_sva.sv =====
// ----------------------------------------------------------------------------
// wrhp_sva
// port-level checks of the header parser, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wrhp_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [1:0]  sample_format_o,
  input logic [15:0] channel_count_o,
  input logic [31:0] sample_rate_o,
  input logic [15:0] block_bytes_o,
  input logic [15:0] sample_bits_o,
  input logic [15:0] valid_bits_o,
  input logic [31:0] speaker_mask_o,
  input logic [31:0] data_bytes_o
);

  logic err_fields_zero;
  logic stereo_or_mono;

  assign err_fields_zero = (sample_format_o == 2'd0) && (channel_count_o == 16'd0) &&
                           (sample_rate_o == 32'd0) && (block_bytes_o == 16'd0) &&
                           (sample_bits_o == 16'd0) && (valid_bits_o == 16'd0) &&
                           (speaker_mask_o == 32'd0) && (data_bytes_o == 32'd0);
  assign stereo_or_mono  = (channel_count_o == 16'd1) || (channel_count_o == 16'd2);

  // stalled result holds
  `WRHP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(status_o) && $stable(data_bytes_o))
  // error results carry only the status
  `WRHP_ASSERT(a_err_zero, !(out_valid_o && (status_o != wrhp_pkg::ST_OK)) || err_fields_zero)
  // default mask replaces unknown for mono and stereo
  `WRHP_ASSERT(a_mask_default, !(out_valid_o && (status_o == wrhp_pkg::ST_OK) &&
    stereo_or_mono) || (speaker_mask_o != wrhp_pkg::MASK_UNKNOWN))
  // no stall while the output register is empty
  `WRHP_ASSERT(a_ready_empty, out_valid_o || in_ready_o)
  // a result follows a taken request
  `WRHP_ASSERT(a_rise_after_req, !$rose(out_valid_o) || $past(in_valid_i && in_ready_o))

endmodule

bind wav_riff_header_parser_top wrhp_sva u_wrhp_sva (.*);
